@@ rtl/q4d_pkg.sv @@
// Package for the Q4_0 block dequantizer: block descriptor type and constants.
// Used by all modules in rtl; depends on nothing else.
`timescale 1ns / 1ps
package q4d_pkg;
  localparam int unsigned NumElems = 32;
  localparam logic [31:0] QnanBits = 32'h7FC00000;
  localparam logic [31:0] InfBits = 32'h7F800000;
  localparam logic [4:0] HalfExpMax = 5'h1F;

  // Classified block handed from the front part to the back part.
  typedef struct packed {
    logic        sign;     // scale sign
    logic        is_nan;   // NaN scale
    logic        is_inf;   // infinite scale
    logic [10:0] sig;      // scale significand with hidden bit
    logic [4:0]  exp_adj;  // exponent offset: biased exponent = h + exp_adj + 102
    logic [127:0] quants;  // bytes 0..15, byte 0 in bits 7..0
    logic [5:0]  count;    // 1..32 after saturation
  } blk_t;
endpackage

@@ rtl/q4d_front.sv @@
// Front part: accepts a block, saturates the count, classifies the scale and
// queues the block in a two-entry FIFO. Depends on q4d_pkg.
`timescale 1ns / 1ps
module q4d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [15:0]       scale_half,
  input  logic [63:0]       nibbles_low,
  input  logic [63:0]       nibbles_high,
  input  logic [5:0]        valid_count,
  output logic              blk_valid,
  input  logic              blk_take,
  output q4d_pkg::blk_t     blk
);
  q4d_pkg::blk_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  q4d_pkg::blk_t in_blk;
  logic          do_push;
  logic          do_pop;
  logic [4:0]    he;

  assign he = scale_half[14:10];
  always_comb begin
    in_blk.sign = scale_half[15];
    in_blk.is_inf = (he == q4d_pkg::HalfExpMax) && (scale_half[9:0] == 10'd0);
    in_blk.is_nan = (he == q4d_pkg::HalfExpMax) && (scale_half[9:0] != 10'd0);
    in_blk.sig = {(he != 5'd0), scale_half[9:0]};
    // subnormal: e = -24 (offset 1); normal: e = he - 25 (offset he)
    in_blk.exp_adj = (he == 5'd0) ? 5'd1 : he;
    in_blk.quants = {nibbles_high, nibbles_low};
    in_blk.count = (valid_count > 6'd32) ? 6'd32 : valid_count;
  end

  // Zero-count blocks produce nothing and are dropped at the door.
  assign full = (fill == 2'd2);
  assign do_push = push && !full && (valid_count != 6'd0);
  assign blk_valid = (fill != 2'd0);
  assign do_pop = blk_take && blk_valid;
  assign blk = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= in_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> fill != 2'd0) else $error("pop from empty queue");
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> (blk.count != 6'd0 && blk.count <= 6'd32))
    else $error("queued block with bad count");
endmodule

@@ rtl/q4d_back.sv @@
// Back part: walks one queued block element by element, forms the exact
// product and holds it in an output register. Depends on q4d_pkg.
`timescale 1ns / 1ps
module q4d_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          blk_valid,
  output logic          blk_take,
  input  q4d_pkg::blk_t blk,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   value,
  output logic          last
);
  logic [4:0]  idx;
  logic        out_valid;
  logic        load;
  logic [3:0]  q;
  logic [7:0]  byte_val;
  logic        ks;
  logic [3:0]  kmag;
  logic [14:0] prod;
  logic [3:0]  h;
  logic        sign;
  logic [31:0] res;
  logic        is_last;

  assign empty = !out_valid;
  assign load = blk_valid && (!out_valid || pop);
  assign is_last = ({1'b0, idx} + 6'd1) == blk.count;
  assign blk_take = load && is_last;

  always_comb begin
    byte_val = blk.quants[{idx[3:0], 3'b000} +: 8];
    q = idx[4] ? byte_val[7:4] : byte_val[3:0];
    ks = !q[3];
    kmag = q[3] ? {1'b0, q[2:0]} : (4'd8 - {1'b0, q[2:0]});
    prod = {11'd0, kmag} * {4'd0, blk.sig};
    sign = blk.sign ^ ks;
    h = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (prod[i]) h = 4'(i);
    end
    if (blk.is_nan || (blk.is_inf && kmag == 4'd0)) begin
      res = q4d_pkg::QnanBits;
    end else if (blk.is_inf) begin
      res = {sign, q4d_pkg::InfBits[30:0]};
    end else if (prod == 15'd0) begin
      res = {sign, 31'd0};
    end else begin
      res = {sign, 8'({4'd0, h} + {3'd0, blk.exp_adj} + 8'd102),
             23'({prod, 8'd0, 15'd0} >> h)};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= res;
      last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= is_last ? 5'd0 : idx + 5'd1;
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_block: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> ({1'b0, idx} < blk.count)) else $error("element index past count");
  a_take_resets: assert property (@(posedge clk) disable iff (rst)
    blk_take |=> idx == 5'd0) else $error("index not rewound after block");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(value)) else $error("result lost");
endmodule

@@ rtl/q4_0_block_dequantizer.sv @@
// Q4_0 block dequantizer top level: front classifier, block queue, back emitter.
// Depends on q4d_pkg, q4d_front and q4d_back.
// A pushed block is written into the queue at the push edge; its first result
// is then registered in the output register, from where it can be popped.
// The back emitter produces one result per cycle while pop keeps its output
// register free; a block of N elements yields N results, 32 for a full block.
// The queue holds two blocks, the one being emitted included.
// Reset: synchronous active-high rst empties the queue and output register.
`timescale 1ns / 1ps
module q4_0_block_dequantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] scale_half,
  input  logic [63:0] nibbles_low,
  input  logic [63:0] nibbles_high,
  input  logic [5:0]  valid_count,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value,
  output logic        last
);
  // Each request with a nonzero count is classified in the front part and queued as a descriptor.
  logic          blk_valid;
  logic          blk_take;
  q4d_pkg::blk_t blk;

  q4d_front u_front (
    .clk, .rst, .push, .full, .scale_half, .nibbles_low, .nibbles_high,
    .valid_count, .blk_valid, .blk_take, .blk
  );

  // The back part issues one element per cycle into its output register while that register is empty or popped.
  q4d_back u_back (
    .clk, .rst, .blk_valid, .blk_take, .blk, .empty, .pop, .value, .last
  );
endmodule
